// ===== hdl/slp_pkg.sv =====
// shared types, codes and reset values for the star layer plotter
package slp_pkg;

   // board modes carried on the mode field
   localparam logic [2:0] MODE_SCROLL      = 3'd0;
   localparam logic [2:0] MODE_BLINK_HALF  = 3'd1;
   localparam logic [2:0] MODE_BLINK       = 3'd2;
   localparam logic [2:0] MODE_SCROLL_MASK = 3'd3;
   localparam logic [2:0] MODE_BLINK_LEFT  = 3'd4;

   // register indexes on the csr port
   localparam logic [2:0] REG_FLIP_X        = 3'd0;
   localparam logic [2:0] REG_FLIP_Y        = 3'd1;
   localparam logic [2:0] REG_SCROLL_POS    = 3'd2;
   localparam logic [2:0] REG_BLINK_PHASE   = 3'd3;
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;
   localparam logic [2:0] REG_COLUMN_MASK   = 3'd6;

   // blink phases
   localparam logic [1:0] BLINK_COL_BIT0 = 2'd0;
   localparam logic [1:0] BLINK_COL_BIT2 = 2'd1;
   localparam logic [1:0] BLINK_Y_BIT1   = 2'd2;

   localparam int CSR_DATA_W = 32;

   localparam logic [8:0] WIDTH_RESET  = 9'd256;
   localparam logic [8:0] HEIGHT_RESET = 9'd224;
   localparam logic [7:0] HALF_X_LIMIT = 8'd240;
   localparam logic [7:0] LEFT_X_LIMIT = 8'd128;
   localparam logic [7:0] ROW_OFFSET   = 8'd16;

   typedef struct packed {
      logic        flip_x;
      logic        flip_y;
      logic [16:0] scroll_pos;
      logic [1:0]  blink_phase;
      logic [8:0]  screen_width;
      logic [8:0]  screen_height;
      logic [31:0] column_mask;
   } cfg_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [8:0] star_x;
      logic [7:0] star_y;
      logic [5:0] star_colour;
   } star_type;

   typedef struct packed {
      logic       plot;
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic [5:0] colour;
   } pixel_type;

endpackage

// ===== hdl/slp_csr.sv =====
// configuration registers of the star layer plotter
module slp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [2:0]                          csr_index,
   input  logic [slp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output slp_pkg::cfg_type                    cfg
);
   import slp_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FLIP_X:        cfg_in.flip_x        = csr_wdata[0];
            REG_FLIP_Y:        cfg_in.flip_y        = csr_wdata[0];
            REG_SCROLL_POS:    cfg_in.scroll_pos    = csr_wdata[16:0];
            REG_BLINK_PHASE:   cfg_in.blink_phase   = csr_wdata[1:0];
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata[8:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata[8:0];
            REG_COLUMN_MASK:   cfg_in.column_mask   = csr_wdata[31:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flip_x        <= 1'b0;
         cfg_ff.flip_y        <= 1'b0;
         cfg_ff.scroll_pos    <= '0;
         cfg_ff.blink_phase   <= '0;
         cfg_ff.screen_width  <= WIDTH_RESET;
         cfg_ff.screen_height <= HEIGHT_RESET;
         cfg_ff.column_mask   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/slp_plot.sv =====
// per-star scroll, visibility, column mask, flip, offset and clip logic
module slp_plot (
   input  slp_pkg::cfg_type   cfg,
   input  slp_pkg::star_type  star,
   output slp_pkg::pixel_type pixel
);
   import slp_pkg::*;

   logic [17:0] sum;
   logic [7:0]  half_x;
   logic [7:0]  raw_x;
   logic [7:0]  raw_y;
   logic        blink_ok;
   logic        mode_ok;
   logic [7:0]  fx;
   logic [7:0]  fy;
   logic [4:0]  col_idx;
   logic        mask_ok;
   logic        clip_ok;
   logic        draw;

   always_comb begin
      sum    = {9'd0, star.star_x} + {1'b0, cfg.scroll_pos};
      half_x = star.star_x[8:1];

      case (cfg.blink_phase)
         BLINK_COL_BIT0: blink_ok = star.star_colour[0];
         BLINK_COL_BIT2: blink_ok = star.star_colour[2];
         BLINK_Y_BIT1:   blink_ok = star.star_y[1];
         default:        blink_ok = 1'b1;
      endcase

      raw_x = half_x;
      raw_y = star.star_y;
      case (star.mode)
         MODE_SCROLL, MODE_SCROLL_MASK: begin
            raw_x   = sum[8:1];
            raw_y   = star.star_y + sum[16:9];
            mode_ok = raw_y[0] ^ raw_x[3];
         end
         MODE_BLINK_HALF: begin
            // checkerboard on halved row
            mode_ok = (star.star_y[1] ^ half_x[3]) && blink_ok && (half_x < HALF_X_LIMIT);
         end
         MODE_BLINK: begin
            mode_ok = (star.star_y[0] ^ half_x[3]) && blink_ok;
         end
         MODE_BLINK_LEFT: begin
            mode_ok = (star.star_y[0] ^ half_x[3]) && blink_ok && (half_x < LEFT_X_LIMIT);
         end
         default: begin
            mode_ok = 1'b0;
         end
      endcase

      // 255 - v on eight bits is the complement
      fx = cfg.flip_x ? ~raw_x : raw_x;
      fy = cfg.flip_y ? ~raw_y : raw_y;

      col_idx = fx[7:3] + 5'd1;
      mask_ok = (star.mode != MODE_SCROLL_MASK) || cfg.column_mask[col_idx];

      clip_ok = (fy >= ROW_OFFSET)
             && ({1'b0, fy - ROW_OFFSET} < cfg.screen_height)
             && ({1'b0, fx} < cfg.screen_width);

      draw = mode_ok && mask_ok && clip_ok;

      pixel.plot    = draw;
      pixel.pixel_x = draw ? fx : 8'd0;
      pixel.pixel_y = draw ? fy - ROW_OFFSET : 8'd0;
      pixel.colour  = draw ? star.star_colour : 6'd0;
   end

endmodule

// ===== hdl/star_layer_plotter.sv =====
// top level of the star layer plotter
//
// one star record is taken on every clock at which start is high; busy is
// always low, so records can stream back to back. each record gives exactly
// one result: the record is registered in star_ff, the plot decision is
// made in one pass of shallow logic, and the result register drives the rsp_
// ports for a single cycle with rsp_valid high. the receiver cannot stall, so
// it must take every result in the cycle it appears. a star that is not drawn
// comes back with rsp_plot low and all other result fields zero. the csr_
// registers take effect on the next clock and are meant to be written only
// while no record is in flight.
module star_layer_plotter (
   input  logic                           clock,
   input  logic                           reset,
   // command side
   input  logic                           start,
   output logic                           busy,
   input  logic [2:0]                     req_mode,
   input  logic [8:0]                     req_star_x,
   input  logic [7:0]                     req_star_y,
   input  logic [5:0]                     req_star_colour,
   // result side
   output logic                           rsp_valid,
   output logic                           rsp_plot,
   output logic [7:0]                     rsp_pixel_x,
   output logic [7:0]                     rsp_pixel_y,
   output logic [5:0]                     rsp_colour,
   // configuration writes
   input  logic                           csr_write,
   input  logic [2:0]                     csr_index,
   input  logic [slp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import slp_pkg::*;

   cfg_type   cfg;
   star_type  star_ff, star_in;
   logic      star_valid_ff;
   pixel_type pixel;
   pixel_type rsp_ff;
   logic      rsp_valid_ff;

   // no stall anywhere: a transfer can start on every clock
   assign busy = 1'b0;

   slp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register
   always_comb begin
      star_in.mode        = req_mode;
      star_in.star_x      = req_star_x;
      star_in.star_y      = req_star_y;
      star_in.star_colour = req_star_colour;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         star_valid_ff <= 1'b0;
      end else begin
         star_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         star_ff <= star_in;
      end
   end

   // single pass of plot logic
   slp_plot u_plot (
      .cfg   (cfg),
      .star  (star_ff),
      .pixel (pixel)
   );

   // result register, one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= star_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (star_valid_ff) begin
         rsp_ff <= pixel;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_plot    = rsp_ff.plot;
   assign rsp_pixel_x = rsp_ff.pixel_x;
   assign rsp_pixel_y = rsp_ff.pixel_y;
   assign rsp_colour  = rsp_ff.colour;

endmodule
